// ----- src/disparity_to_point_reprojection_core_defines.svh -----
// assertion macros shared by the reprojection core
`ifndef DISPARITY_TO_POINT_REPROJECTION_CORE_DEFINES_SVH
`define DISPARITY_TO_POINT_REPROJECTION_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define D2P_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define D2P_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/d2p_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d2p_pkg
// shared widths, codes and types of the disparity reprojection core
// ----------------------------------------------------------------------------
package d2p_pkg;

    localparam int CFG_W      = 24;
    localparam int FOCAL_W    = 24;
    localparam int CXY_W      = 20;
    localparam int CDIFF_W    = 21;
    localparam int BASE_W     = 24;
    localparam int COORD_W    = 12;
    localparam int DISP_W     = 16;
    localparam int COLOR_W    = 8;
    localparam int XY_W       = 24;
    localparam int Z_W        = 19;
    localparam int DEN_W      = 22;
    localparam int NXY_W      = 21;
    localparam int PXY_W      = NXY_W + BASE_W;
    localparam int PFB_W      = FOCAL_W + 1 + BASE_W;
    localparam int DD_W       = 32;
    localparam int FAR_W      = 41;
    localparam int NUM_W      = 56;
    localparam int MM_PER_M   = 1000;
    localparam int FAR_SCALE  = 512000;
    localparam int DEFAULT_QUEUE_DEPTH = 2;

    localparam logic OP_SCAN   = 1'b0;
    localparam logic OP_REPROJ = 1'b1;

    typedef enum logic [2:0] {
        CFG_FOCAL = 3'd0,
        CFG_CX    = 3'd1,
        CFG_CY    = 3'd2,
        CFG_CDIFF = 3'd3,
        CFG_BASE  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic        [FOCAL_W-1:0] focal;
        logic        [CXY_W-1:0]   cx;
        logic        [CXY_W-1:0]   cy;
        logic signed [CDIFF_W-1:0] cdiff;
        logic signed [BASE_W-1:0]  base;
    } t_cfg;

    typedef struct packed {
        logic                      bad;
        logic signed [PFB_W-1:0]   pfb;
        logic signed [PXY_W-1:0]   pxb;
        logic signed [PXY_W-1:0]   pyb;
        logic signed [DEN_W-1:0]   den;
        logic        [COORD_W-1:0] col;
        logic        [COORD_W-1:0] row;
        logic        [COLOR_W-1:0] blue;
        logic        [COLOR_W-1:0] green;
        logic        [COLOR_W-1:0] red;
    } t_job;

endpackage
`default_nettype wire

// ----- src/d2p_pix_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d2p_pix_if
// pixel channel: opcode, position, disparity and color
// ----------------------------------------------------------------------------
interface d2p_pix_if import d2p_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic        [COORD_W-1:0] col;
    logic        [COORD_W-1:0] row;
    logic signed [DISP_W-1:0]  disparity;
    logic        [COLOR_W-1:0] blue;
    logic        [COLOR_W-1:0] green;
    logic        [COLOR_W-1:0] red;

    modport source (output valid, opcode, col, row, disparity, blue, green, red,
                    input ready);
    modport sink   (input valid, opcode, col, row, disparity, blue, green, red,
                    output ready);
endinterface
`default_nettype wire

// ----- src/d2p_pt_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d2p_pt_if
// point channel: validity, position, coordinates in metres and color
// ----------------------------------------------------------------------------
interface d2p_pt_if import d2p_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic                      valid_res;
    logic        [COORD_W-1:0] out_col;
    logic        [COORD_W-1:0] out_row;
    logic signed [XY_W-1:0]    x_m_q16;
    logic signed [XY_W-1:0]    y_m_q16;
    logic signed [Z_W-1:0]     z_m_q16;
    logic        [COLOR_W-1:0] out_blue;
    logic        [COLOR_W-1:0] out_green;
    logic        [COLOR_W-1:0] out_red;

    modport source (output valid, valid_res, out_col, out_row, x_m_q16, y_m_q16,
                    z_m_q16, out_blue, out_green, out_red, input ready);
    modport sink   (input valid, valid_res, out_col, out_row, x_m_q16, y_m_q16,
                    z_m_q16, out_blue, out_green, out_red, output ready);
endinterface
`default_nettype wire

// ----- src/d2p_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d2p_front
// accepts pixels, tracks the minimum disparity, forms products and flags
// ----------------------------------------------------------------------------
module d2p_front import d2p_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    d2p_pix_if.sink   i_pix,
    input  wire logic i_full,
    output logic      o_push,
    output t_job      o_job
);

    logic signed [DISP_W-1:0] r_min;
    logic signed [DISP_W-1:0] n_min;
    logic                     acc;
    logic signed [DEN_W-1:0]  den;
    logic signed [NXY_W-1:0]  nx;
    logic signed [NXY_W-1:0]  ny;

    assign i_pix.ready = !i_full;
    assign acc         = i_pix.valid && !i_full;

    // denominator and centered coordinates, all with eight fraction bits
    assign den = $signed({i_cfg.cdiff[CDIFF_W-1], i_cfg.cdiff})
               - $signed({{2{i_pix.disparity[DISP_W-1]}}, i_pix.disparity, 4'b0000});
    assign nx  = $signed({1'b0, i_pix.col, 8'h00}) - $signed({1'b0, i_cfg.cx});
    assign ny  = $signed({1'b0, i_pix.row, 8'h00}) - $signed({1'b0, i_cfg.cy});

    // products and rejection flags for the back end
    always_comb begin
        o_job.pfb   = $signed({1'b0, i_cfg.focal}) * i_cfg.base;
        o_job.pxb   = nx * i_cfg.base;
        o_job.pyb   = ny * i_cfg.base;
        o_job.den   = den;
        o_job.col   = i_pix.col;
        o_job.row   = i_pix.row;
        o_job.blue  = i_pix.blue;
        o_job.green = i_pix.green;
        o_job.red   = i_pix.red;
        o_job.bad   = (i_pix.disparity == r_min) || (i_pix.disparity == '0)
                   || (den == '0) || (i_cfg.base == '0)
                   || (nx == '0 && ny == '0 && i_cfg.focal == '0);
    end

    assign o_push = acc && (i_pix.opcode == OP_REPROJ);

    // running minimum, restarted at the first pixel of the frame
    always_comb begin
        n_min = r_min;
        if (acc && i_pix.opcode == OP_SCAN) begin
            if ((i_pix.col == '0 && i_pix.row == '0) || i_pix.disparity < r_min) begin
                n_min = i_pix.disparity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
        end else begin
            r_min <= n_min;
        end
    end

endmodule
`default_nettype wire

// ----- src/d2p_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d2p_queue
// small register queue of jobs between front and back end
// ----------------------------------------------------------------------------
module d2p_queue import d2p_pkg::*; #(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_job      o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- src/d2p_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// d2p_back
// far test, rounded bit-serial division of x, y, z, saturation of x and y, output register
// ----------------------------------------------------------------------------
`include "disparity_to_point_reprojection_core_defines.svh"
module d2p_back import d2p_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_empty,
    input  wire t_job i_job,
    output logic      o_pop,
    d2p_pt_if.source  o_pt
);

    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_PREP  = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_FIN   = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state               r_state;
    t_job                 r_job;
    logic                 r_bad;
    logic [DD_W-1:0]      r_ud;
    logic [FAR_W-1:0]     r_far;
    logic [PFB_W-2:0]     r_fmag;
    logic [PXY_W-1:0]     r_xmag;
    logic [PXY_W-1:0]     r_ymag;
    logic                 r_negx;
    logic                 r_negy;
    logic                 r_negz;
    logic [NUM_W-1:0]     r_qx;
    logic [NUM_W-1:0]     r_qy;
    logic [NUM_W-1:0]     r_qz;
    logic [DD_W-1:0]      r_rx;
    logic [DD_W-1:0]      r_ry;
    logic [DD_W-1:0]      r_rz;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_o_vres;
    logic [XY_W-1:0]      r_o_x;
    logic [XY_W-1:0]      r_o_y;
    logic [Z_W-1:0]       r_o_z;
    logic [DEN_W-1:0]     dmag;
    logic [NUM_W+DD_W-1:0] sx;
    logic [NUM_W+DD_W-1:0] sy;
    logic [NUM_W+DD_W-1:0] sz;

    // one restoring step: returns {remainder, shifted numerator/quotient}
    function automatic logic [NUM_W+DD_W-1:0] div_step(
        input logic [DD_W-1:0]  rem,
        input logic [NUM_W-1:0] num,
        input logic [DD_W-1:0]  ud
    );
        logic [DD_W:0] t;
        logic          qb;
        t  = {rem, num[NUM_W-1]};
        qb = (t >= {1'b0, ud});
        if (qb) begin
            t = t - {1'b0, ud};
        end
        return {t[DD_W-1:0], num[NUM_W-2:0], qb};
    endfunction

    // sign and 24-bit saturation of a quotient magnitude
    function automatic logic [XY_W-1:0] sat_xy(
        input logic [NUM_W-1:0] m,
        input logic             neg
    );
        logic [NUM_W-1:0] mn;
        mn = -m;
        if (neg) begin
            return (m > NUM_W'(64'd8388608)) ? {1'b1, {(XY_W-1){1'b0}}} : mn[XY_W-1:0];
        end
        return (m > NUM_W'(64'd8388607)) ? {1'b0, {(XY_W-1){1'b1}}} : m[XY_W-1:0];
    endfunction

    assign dmag = r_job.den[DEN_W-1] ? DEN_W'(-r_job.den) : DEN_W'(r_job.den);
    assign sx   = div_step(r_rx, r_qx, r_ud);
    assign sy   = div_step(r_ry, r_qy, r_ud);
    assign sz   = div_step(r_rz, r_qz, r_ud);
    assign o_pop = (r_state == ST_IDLE) && !i_empty;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) r_state <= ST_SETUP;
                end
                ST_SETUP: r_state <= ST_PREP;
                ST_PREP: begin
                    r_cnt   <= '0;
                    r_state <= (r_job.bad || r_fmag >= (PFB_W-1)'(r_far)) ? ST_FIN : ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(NUM_W - 1)) r_state <= ST_FIN;
                end
                ST_FIN: r_state <= ST_DONE;
                ST_DONE: begin
                    if (o_pt.ready) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) r_job <= i_job;
            end
            ST_SETUP: begin
                r_ud   <= DD_W'(dmag * MM_PER_M);
                r_far  <= FAR_W'(dmag * FAR_SCALE);
                r_fmag <= r_job.pfb[PFB_W-1] ? (PFB_W-1)'(-r_job.pfb) : (PFB_W-1)'(r_job.pfb);
                r_xmag <= r_job.pxb[PXY_W-1] ? PXY_W'(-r_job.pxb) : PXY_W'(r_job.pxb);
                r_ymag <= r_job.pyb[PXY_W-1] ? PXY_W'(-r_job.pyb) : PXY_W'(r_job.pyb);
                r_negx <= r_job.pxb[PXY_W-1] ^ r_job.den[DEN_W-1];
                r_negy <= r_job.pyb[PXY_W-1] ^ r_job.den[DEN_W-1];
                r_negz <= r_job.pfb[PFB_W-1] ^ r_job.den[DEN_W-1];
            end
            ST_PREP: begin
                r_bad <= r_job.bad || r_fmag >= (PFB_W-1)'(r_far);
                r_qx  <= NUM_W'({r_xmag, 8'h00}) + NUM_W'(r_ud >> 1);
                r_qy  <= NUM_W'({r_ymag, 8'h00}) + NUM_W'(r_ud >> 1);
                r_qz  <= NUM_W'({r_fmag, 8'h00}) + NUM_W'(r_ud >> 1);
                r_rx  <= '0;
                r_ry  <= '0;
                r_rz  <= '0;
            end
            ST_DIV: begin
                {r_rx, r_qx} <= sx;
                {r_ry, r_qy} <= sy;
                {r_rz, r_qz} <= sz;
            end
            ST_FIN: begin
                r_o_vres <= !r_bad;
                r_o_x    <= r_bad ? '0 : sat_xy(r_qx, r_negx);
                r_o_y    <= r_bad ? '0 : sat_xy(r_qy, r_negy);
                r_o_z    <= r_bad ? '0 : (r_negz ? Z_W'(-r_qz) : r_qz[Z_W-1:0]);
            end
            default: begin
            end
        endcase
    end

    // output register
    assign o_pt.valid     = (r_state == ST_DONE);
    assign o_pt.valid_res = r_o_vres;
    assign o_pt.out_col   = r_job.col;
    assign o_pt.out_row   = r_job.row;
    assign o_pt.x_m_q16   = r_o_x;
    assign o_pt.y_m_q16   = r_o_y;
    assign o_pt.z_m_q16   = r_o_z;
    assign o_pt.out_blue  = r_job.blue;
    assign o_pt.out_green = r_job.green;
    assign o_pt.out_red   = r_job.red;

    `D2P_ASSERT_IMPL(a_pop_when_idle, i_clk, i_rst_n, o_pop, (r_state == ST_IDLE && !i_empty), "pop outside idle")
    `D2P_ASSERT_NEXT(a_div_ends, i_clk, i_rst_n, (r_state == ST_DIV && r_cnt == CNT_W'(NUM_W - 1)), (r_state == ST_FIN), "division did not finish")
    `D2P_ASSERT_NEXT(a_bad_zero, i_clk, i_rst_n, (r_state == ST_FIN && r_bad), (r_o_x == '0 && r_o_y == '0 && r_o_z == '0 && !r_o_vres), "rejected point not zeroed")

endmodule
`default_nettype wire

// ----- src/disparity_to_point_reprojection_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Disparity to point reprojection core.
// Configuration: write i_cfg_we with i_cfg_index and i_cfg_data while idle;
// registers are focal length, center x, center y, center difference and
// baseline, all with eight fraction bits; unknown indexes are ignored.
// i_pix carries pixels. Opcode scan updates the running minimum disparity
// (restarted at pixel 0,0) and gives no result; scan pixels transfer one per
// cycle while the job queue has room. Opcode reproject gives one point on o_pt.
// A reproject pixel passes through the back end in steps: setup, a far-point
// test, a 56-step bit-serial division of x, y and z against one shared divisor,
// a finish step, and the output register; the division loop sets the rate.
// The front keeps accepting into the job queue while a point waits on o_pt, so
// a stalled receiver only stops input once the queue is full.
// Reset (synchronous, active low) clears configuration, minimum and queue.
// ----------------------------------------------------------------------------
// disparity_to_point_reprojection_core
// top level: configuration registers, front end, job queue, back end
// ----------------------------------------------------------------------------
module disparity_to_point_reprojection_core import d2p_pkg::*; #(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    d2p_pix_if.sink               i_pix,
    d2p_pt_if.source              o_pt
);

    t_cfg r_cfg;
    logic push;
    logic full;
    logic pop;
    logic empty;
    t_job job_in;
    t_job job_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FOCAL: r_cfg.focal <= i_cfg_data[FOCAL_W-1:0];
                CFG_CX:    r_cfg.cx    <= i_cfg_data[CXY_W-1:0];
                CFG_CY:    r_cfg.cy    <= i_cfg_data[CXY_W-1:0];
                CFG_CDIFF: r_cfg.cdiff <= i_cfg_data[CDIFF_W-1:0];
                CFG_BASE:  r_cfg.base  <= i_cfg_data[BASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front end
    d2p_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_pix   (i_pix),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job_in)
    );

    // job queue
    d2p_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (job_out)
    );

    // back end
    d2p_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_pt    (o_pt)
    );

endmodule
`default_nettype wire
